>>> rtl/core/thermal_spi_frame_assembler_macros.svh
// Assertion macros shared by the RTL that checks itself.
`ifndef THERMAL_SPI_FRAME_ASSEMBLER_MACROS_SVH
`define THERMAL_SPI_FRAME_ASSEMBLER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TSFA_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("tsfa assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define TSFA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("tsfa assertion failed");

`endif

>>> rtl/core/tsfa_pkg.sv
package tsfa_pkg;

    localparam int FRAME_WIDTH  = 80;
    localparam int FRAME_HEIGHT = 60;

    localparam logic [6:0]  COL_LAST       = 7'(FRAME_WIDTH - 1);
    localparam logic [5:0]  ROW_LAST       = 6'(FRAME_HEIGHT - 1);
    localparam logic [3:0]  DISCARD_NIBBLE = 4'hF;
    localparam logic [15:0] PIX_MIN_RESET  = 16'hFFFF;
    localparam logic [8:0]  DISCARD_SAT    = 9'h1FF;
    localparam logic [8:0]  DISCARD_LIMIT_RESET = 9'd300;
    localparam logic [9:0]  RESYNC_LIMIT_RESET  = 10'd750;

    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_ABORT = 1'b1;

    // Register indexes of the configuration port.
    typedef enum logic [0:0] {
        CFG_DISCARD_LIMIT = 1'b0,
        CFG_RESYNC_LIMIT  = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       packet_start;
    } byte_item_t;

    typedef struct packed {
        logic        kind;
        logic [15:0] pixel_value;
        logic [5:0]  pixel_row;
        logic [6:0]  pixel_column;
        logic        frame_last;
        logic [15:0] frame_min;
        logic [15:0] frame_max;
        logic        long_pause;
    } result_t;

endpackage

>>> rtl/core/tsfa_skid.sv
module tsfa_skid (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  tsfa_pkg::result_t in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output tsfa_pkg::result_t out_data
);
    import tsfa_pkg::*;

    logic    out_valid_reg;
    logic    skid_valid_reg;
    result_t out_data_reg;
    result_t skid_data_reg;
    logic    out_take;

    // The output slot can load when it is empty or being drained.
    assign out_take  = out_ready || !out_valid_reg;
    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_take) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= in_valid;
            end
        end else if (in_valid && !skid_valid_reg) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_take) begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : in_data;
        end
        if (!out_take && !skid_valid_reg) begin
            skid_data_reg <= in_data;
        end
    end

endmodule

>>> rtl/core/thermal_spi_frame_assembler.sv
// Video-over-SPI frame receiver.
// The s_ channel carries one received SPI byte per transaction, with
// packet_start marking the first byte of each packet. Each packet holds
// four header bytes and then the row's pixels, two bytes each, high first.
// The m_ channel carries at most one result per accepted byte: either a
// pixel with its row and column (with the frame minimum and maximum on the
// last pixel of a frame), or an abort that tells the consumer to drop the
// partial frame it has received so far.
// Each byte is decoded in the cycle it is accepted; its result is registered
// in the output buffer that drives m_. One byte is taken every cycle while
// s_ready is high, a rate set by the state update that feeds the next byte.
// A two-entry output buffer sits in front of m_: when the receiver stalls,
// one more result is absorbed, and then s_ready drops until the receiver
// takes a transaction. s_ready is driven straight from a register.
// The cfg port writes the discard error limit (index 0) and the resync
// limit (index 1); write it only while the block is idle.
// Reset (aresetn low, synchronous) restores both limits to their defaults,
// clears all counters, restarts at row zero and empties the output buffer.
`include "thermal_spi_frame_assembler_macros.svh"

module thermal_spi_frame_assembler (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  tsfa_pkg::byte_item_t   s_payload,
    output logic                   m_valid,
    input  logic                   m_ready,
    output tsfa_pkg::result_t      m_payload,
    input  logic                   cfg_write_enable,
    input  logic [0:0]             cfg_index,
    input  logic [9:0]             cfg_data
);
    import tsfa_pkg::*;

    // Where the current packet stands.
    typedef enum logic [3:0] {
        DISP_IDLE   = 4'b0001,
        DISP_HEADER = 4'b0010,
        DISP_ROW    = 4'b0100,
        DISP_SKIP   = 4'b1000
    } disp_t;

    disp_t       disp_reg, disp_next;
    logic [7:0]  byte_pos_reg, byte_pos_next;
    logic [5:0]  expected_row_reg, expected_row_next;
    logic [7:0]  held_reg, held_next;
    logic [8:0]  discard_count_reg, discard_count_next;
    logic [9:0]  resync_count_reg, resync_count_next;
    logic [15:0] run_min_reg, run_min_next;
    logic [15:0] run_max_reg, run_max_next;
    logic [8:0]  discard_limit_reg;
    logic [9:0]  resync_limit_reg;

    logic        s_fire;
    logic        abort_now;
    logic        res_valid;
    result_t     res;
    logic [7:0]  pos_inc;
    logic [7:0]  offset;
    logic [6:0]  col;
    logic [15:0] value;
    logic [15:0] new_min;
    logic [15:0] new_max;
    logic [8:0]  discard_inc;
    logic [10:0] resync_inc;

    assign s_fire = s_valid && s_ready;

    // Shared arithmetic for the byte under decode.
    assign pos_inc     = byte_pos_reg + 8'd1;
    assign offset      = pos_inc - 8'd4;
    assign col         = offset[7:1];
    assign value       = {held_reg, s_payload.data_byte};
    assign new_min     = (value < run_min_reg) ? value : run_min_reg;
    assign new_max     = (value > run_max_reg) ? value : run_max_reg;
    assign discard_inc = (discard_count_reg != DISCARD_SAT) ?
                         discard_count_reg + 9'd1 : discard_count_reg;
    assign resync_inc  = {1'b0, resync_count_reg} + 11'd1;

    always_comb begin
        disp_next          = disp_reg;
        byte_pos_next      = byte_pos_reg;
        expected_row_next  = expected_row_reg;
        held_next          = held_reg;
        discard_count_next = discard_count_reg;
        resync_count_next  = resync_count_reg;
        run_min_next       = run_min_reg;
        run_max_next       = run_max_reg;
        abort_now          = 1'b0;
        res_valid          = 1'b0;
        res                = '0;

        if (s_fire) begin
            if (s_payload.packet_start) begin
                byte_pos_next = 8'd0;
                held_next     = s_payload.data_byte;
                if (s_payload.data_byte[3:0] == DISCARD_NIBBLE) begin
                    // A discard packet: count it and skip its body.
                    disp_next          = DISP_SKIP;
                    discard_count_next = discard_inc;
                    abort_now          = (discard_inc > discard_limit_reg);
                end else begin
                    disp_next = DISP_HEADER;
                end
            end else if (disp_reg == DISP_HEADER) begin
                byte_pos_next = pos_inc;
                if (s_payload.data_byte != {2'b00, expected_row_reg}) begin
                    abort_now = 1'b1;
                end else begin
                    disp_next = DISP_ROW;
                end
            end else if (disp_reg == DISP_ROW) begin
                byte_pos_next = pos_inc;
                if (pos_inc >= 8'd4) begin
                    if (!offset[0]) begin
                        held_next = s_payload.data_byte;
                    end else begin
                        res_valid        = 1'b1;
                        res.kind         = KIND_PIXEL;
                        res.pixel_value  = value;
                        res.pixel_row    = expected_row_reg;
                        res.pixel_column = col;
                        run_min_next     = new_min;
                        run_max_next     = new_max;
                        if (col >= COL_LAST) begin
                            disp_next = DISP_SKIP;
                            if (expected_row_reg >= ROW_LAST) begin
                                // Whole frame received: report and start over.
                                res.frame_last     = 1'b1;
                                res.frame_min      = new_min;
                                res.frame_max      = new_max;
                                discard_count_next = '0;
                                resync_count_next  = '0;
                                expected_row_next  = '0;
                                run_min_next       = PIX_MIN_RESET;
                                run_max_next       = '0;
                            end else begin
                                expected_row_next = expected_row_reg + 6'd1;
                            end
                        end
                    end
                end
            end

            if (abort_now) begin
                // Drop the frame attempt and skip the rest of this packet.
                disp_next         = DISP_SKIP;
                expected_row_next = '0;
                run_min_next      = PIX_MIN_RESET;
                run_max_next      = '0;
                res_valid         = 1'b1;
                res.kind          = KIND_ABORT;
                if (resync_inc >= {1'b0, resync_limit_reg}) begin
                    res.long_pause    = 1'b1;
                    resync_count_next = '0;
                end else begin
                    resync_count_next = resync_inc[9:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            disp_reg          <= DISP_IDLE;
            byte_pos_reg      <= '0;
            expected_row_reg  <= '0;
            held_reg          <= '0;
            discard_count_reg <= '0;
            resync_count_reg  <= '0;
            run_min_reg       <= PIX_MIN_RESET;
            run_max_reg       <= '0;
        end else begin
            disp_reg          <= disp_next;
            byte_pos_reg      <= byte_pos_next;
            expected_row_reg  <= expected_row_next;
            held_reg          <= held_next;
            discard_count_reg <= discard_count_next;
            resync_count_reg  <= resync_count_next;
            run_min_reg       <= run_min_next;
            run_max_reg       <= run_max_next;
        end
    end

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            discard_limit_reg <= DISCARD_LIMIT_RESET;
            resync_limit_reg  <= RESYNC_LIMIT_RESET;
        end else if (cfg_write_enable) begin
            unique case (cfg_index)
                CFG_DISCARD_LIMIT: discard_limit_reg <= cfg_data[8:0];
                CFG_RESYNC_LIMIT:  resync_limit_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // Output buffer between the decoder and the m_ channel.
    tsfa_skid u_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_fire && res_valid),
        .in_ready  (s_ready),
        .in_data   (res),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (m_payload)
    );

    // The input can only stall when a result already waits at the output.
    `TSFA_ASSERT_SAME(a_stall_needs_output, !s_ready, m_valid)
    // An abort always restarts the frame at row zero with fresh extremes.
    `TSFA_ASSERT_NEXT(a_abort_restarts, s_fire && abort_now,
        expected_row_reg == 6'd0 && run_min_reg == PIX_MIN_RESET && run_max_reg == 16'd0)
    // Reported frame extremes bracket the last pixel.
    `TSFA_ASSERT_SAME(a_last_in_range, m_valid && m_payload.frame_last,
        m_payload.frame_min <= m_payload.pixel_value &&
        m_payload.pixel_value <= m_payload.frame_max)

endmodule
